>>> src/irpde_pkg.sv
package irpde_pkg;

    localparam int DUR_W     = 10;
    localparam int BYTE_W    = 8;
    localparam int REG_IDX_W = 3;
    localparam int SEG_IDX_W = 5;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_HDR_MARK   = 3'd0,
        REG_HDR_SPACE  = 3'd1,
        REG_BIT_MARK   = 3'd2,
        REG_ONE_SPACE  = 3'd3,
        REG_ZERO_SPACE = 3'd4,
        REG_FTR_MARK   = 3'd5,
        REG_FTR_SPACE  = 3'd6
    } reg_idx_t;

    localparam logic [DUR_W-1:0] HDR_MARK_RST   = 10'd90;
    localparam logic [DUR_W-1:0] HDR_SPACE_RST  = 10'd45;
    localparam logic [DUR_W-1:0] BIT_MARK_RST   = 10'd6;
    localparam logic [DUR_W-1:0] ONE_SPACE_RST  = 10'd10;
    localparam logic [DUR_W-1:0] ZERO_SPACE_RST = 10'd20;
    localparam logic [DUR_W-1:0] FTR_MARK_RST   = 10'd6;
    localparam logic [DUR_W-1:0] FTR_SPACE_RST  = 10'd400;

    localparam logic [SEG_IDX_W-1:0] SEG_HDR_MARK  = 5'd0;
    localparam logic [SEG_IDX_W-1:0] SEG_HDR_SPACE = 5'd1;
    localparam logic [SEG_IDX_W-1:0] SEG_FIRST_BIT = 5'd2;
    localparam logic [SEG_IDX_W-1:0] SEG_LAST_BIT  = 5'd17;
    localparam logic [SEG_IDX_W-1:0] SEG_FTR_MARK  = 5'd18;
    localparam logic [SEG_IDX_W-1:0] SEG_FTR_SPACE = 5'd19;

endpackage

>>> src/ir_pulse_distance_encoder.sv
// Channel   Direction  tdata (low bit up)           tuser        tlast
// s_        in         data_byte[7:0]               first_byte   last_byte
// m_        out        duration[9:0], 6 zero bits   carrier_on   segment_last
// cfg_      in         write enable, index[2:0], wdata[9:0] (no handshake)
//
// One segment leaves per cycle while m_ is not stalled and a byte is on hand; a byte makes 16 to 20 segments,
// set by the segment index counter stepping through header, bits and footer.
// The next byte is taken in the cycle its predecessor's final segment loads
// the output register, so bytes stream without gaps.
// aresetn is synchronous, active low; it restores the default durations.
// A stalled m_ side holds the output register and the segment counter.
module ir_pulse_distance_encoder
    import irpde_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // data_byte[7:0]
    input  logic                 s_tuser,   // first_byte
    input  logic                 s_tlast,   // last_byte

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // duration[9:0], zero fill [15:10]
    output logic                 m_tuser,   // carrier_on
    output logic                 m_tlast,   // segment_last

    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [DUR_W-1:0]     cfg_wr_data
);

    logic [DUR_W-1:0] hdr_mark_reg, hdr_space_reg, bit_mark_reg, one_space_reg;
    logic [DUR_W-1:0] zero_space_reg, ftr_mark_reg, ftr_space_reg;

    logic [BYTE_W-1:0]    byte_reg;
    logic                 first_reg, last_reg;
    logic                 item_valid_reg;
    logic [SEG_IDX_W-1:0] seg_idx_reg;

    logic                 m_valid_reg;
    logic                 m_mark_reg, m_last_reg;
    logic [DUR_W-1:0]     m_dur_reg;

    logic                 load, seg_done, s_accept;
    logic [SEG_IDX_W-1:0] end_idx, bit_off;
    logic [2:0]           bit_sel;
    logic                 seg_mark;
    logic [DUR_W-1:0]     seg_dur;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_mark_reg   <= HDR_MARK_RST;
            hdr_space_reg  <= HDR_SPACE_RST;
            bit_mark_reg   <= BIT_MARK_RST;
            one_space_reg  <= ONE_SPACE_RST;
            zero_space_reg <= ZERO_SPACE_RST;
            ftr_mark_reg   <= FTR_MARK_RST;
            ftr_space_reg  <= FTR_SPACE_RST;
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_index))
                REG_HDR_MARK:   hdr_mark_reg   <= cfg_wr_data;
                REG_HDR_SPACE:  hdr_space_reg  <= cfg_wr_data;
                REG_BIT_MARK:   bit_mark_reg   <= cfg_wr_data;
                REG_ONE_SPACE:  one_space_reg  <= cfg_wr_data;
                REG_ZERO_SPACE: zero_space_reg <= cfg_wr_data;
                REG_FTR_MARK:   ftr_mark_reg   <= cfg_wr_data;
                REG_FTR_SPACE:  ftr_space_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign load     = item_valid_reg && (!m_valid_reg || m_tready);
    assign end_idx  = last_reg ? SEG_FTR_SPACE : SEG_LAST_BIT;
    assign seg_done = load && (seg_idx_reg == end_idx);
    assign s_tready = !item_valid_reg || seg_done;
    assign s_accept = s_tvalid && s_tready;

    assign bit_off = seg_idx_reg - SEG_FIRST_BIT;
    assign bit_sel = bit_off[3:1];

    always_comb begin
        seg_mark = !seg_idx_reg[0];
        if (seg_idx_reg == SEG_HDR_MARK) begin
            seg_dur = hdr_mark_reg;
        end else if (seg_idx_reg == SEG_HDR_SPACE) begin
            seg_dur = hdr_space_reg;
        end else if (seg_idx_reg == SEG_FTR_MARK) begin
            seg_dur = ftr_mark_reg;
        end else if (seg_idx_reg == SEG_FTR_SPACE) begin
            seg_dur = ftr_space_reg;
        end else if (seg_mark) begin
            seg_dur = bit_mark_reg;
        end else begin
            seg_dur = byte_reg[bit_sel] ? one_space_reg : zero_space_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            seg_idx_reg    <= SEG_HDR_MARK;
        end else if (s_accept) begin
            item_valid_reg <= 1'b1;
            seg_idx_reg    <= s_tuser ? SEG_HDR_MARK : SEG_FIRST_BIT;
        end else if (seg_done) begin
            item_valid_reg <= 1'b0;
        end else if (load) begin
            seg_idx_reg    <= seg_idx_reg + SEG_IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            byte_reg  <= s_tdata;
            first_reg <= s_tuser;
            last_reg  <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_mark_reg <= seg_mark;
            m_dur_reg  <= seg_dur;
            m_last_reg <= seg_idx_reg == end_idx;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(16-DUR_W){1'b0}}, m_dur_reg};
    assign m_tuser  = m_mark_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid_reg |-> seg_idx_reg <= end_idx)
        else $error("segment index past end of byte");

    a_hdr_only_first: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid_reg && !first_reg |-> seg_idx_reg >= SEG_FIRST_BIT)
        else $error("header segment without first byte");

    a_last_is_space: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> !m_tuser)
        else $error("final segment is a mark");

    a_done_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        seg_done && !s_tvalid |=> !item_valid_reg)
        else $error("item held after final segment");
`endif

endmodule

>>> test/ir_pulse_distance_encoder_tb.sv
module ir_pulse_distance_encoder_tb;
    import irpde_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                   NUM_LEN_REGS = 7;
    localparam logic [REG_IDX_W-1:0] REG_IDX_NONE = 3'd7;
    localparam logic [DUR_W-1:0]     DUR_MAX      = 10'd1023;
    localparam int                   HOLD_CYCLES  = 300;
    localparam int                   PHASE_ITEMS  = 74;
    localparam int                   NUM_PHASES   = 6;
    localparam int                   MAX_REPORTS  = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              first;
        logic              last;
    } ir_byte_t;

    typedef struct packed {
        logic             carrier;
        logic [DUR_W-1:0] dur;
        logic             last;
    } ir_seg_t;

    logic                 aclk;
    logic                 aresetn     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata     = '0;
    logic                 s_tuser     = 1'b0;
    logic                 s_tlast     = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [15:0]          m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 cfg_wr_en   = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index   = '0;
    logic [DUR_W-1:0]     cfg_wr_data = '0;

    ir_byte_t         byte_q [$];
    ir_seg_t          seg_q [$];
    logic [DUR_W-1:0] len_reg [0:NUM_LEN_REGS-1];

    logic in_taken  = 1'b0;
    int   send_gap  = 0;
    int   ready_gap = 0;
    int   hold_left = 0;
    logic held_once = 1'b0;
    logic quiet     = 1'b0;
    logic squeeze   = 1'b0;
    int   mismatch_count = 0;

    ir_pulse_distance_encoder uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 24);
    endfunction

    function automatic void encode_byte(input ir_byte_t b);
        ir_seg_t segs [$];
        ir_seg_t s;
        if (b.first) begin
            segs.push_back('{1'b1, len_reg[REG_HDR_MARK], 1'b0});
            segs.push_back('{1'b0, len_reg[REG_HDR_SPACE], 1'b0});
        end
        for (int i = 0; i < BYTE_W; i++) begin
            segs.push_back('{1'b1, len_reg[REG_BIT_MARK], 1'b0});
            if (b.data[i])
                segs.push_back('{1'b0, len_reg[REG_ONE_SPACE], 1'b0});
            else
                segs.push_back('{1'b0, len_reg[REG_ZERO_SPACE], 1'b0});
        end
        if (b.last) begin
            segs.push_back('{1'b1, len_reg[REG_FTR_MARK], 1'b0});
            segs.push_back('{1'b0, len_reg[REG_FTR_SPACE], 1'b0});
        end
        foreach (segs[i]) begin
            s = segs[i];
            s.last = (i == segs.size() - 1);
            seg_q.push_back(s);
        end
    endfunction

    // sender: hold the beat until taken, then idle or offer the next byte
    always @(negedge aclk) begin
        ir_byte_t b;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_taken) begin
        end else if (send_gap > 0) begin
            s_tvalid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (byte_q.size() > 0) begin
            b = byte_q.pop_front();
            s_tdata  <= b.data;
            s_tuser  <= b.first;
            s_tlast  <= b.last;
            s_tvalid <= 1'b1;
            send_gap <= quiet ? 0 : pick_gap();
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // receiver: random stalls, one long hold-off during the squeeze phase
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (squeeze && !held_once) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            held_once <= 1'b1;
        end else if (ready_gap > 0) begin
            m_tready  <= 1'b0;
            ready_gap <= ready_gap - 1;
        end else begin
            m_tready  <= 1'b1;
            ready_gap <= quiet ? 0 : pick_gap();
        end
    end

    always @(posedge aclk) begin
        ir_seg_t exp_seg;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                if (seg_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected segment: carrier=%0b tdata=%h last=%0b",
                                 m_tuser, m_tdata, m_tlast);
                end else begin
                    exp_seg = seg_q.pop_front();
                    if (m_tuser !== exp_seg.carrier || m_tlast !== exp_seg.last ||
                        m_tdata !== {6'b0, exp_seg.dur}) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("segment mismatch: expected carrier=%0b dur=%0d last=%0b",
                                     exp_seg.carrier, exp_seg.dur, exp_seg.last);
                            $display("                  got carrier=%0b tdata=%h last=%0b",
                                     m_tuser, m_tdata, m_tlast);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                encode_byte('{s_tdata, s_tuser, s_tlast});
        end
    end

    task automatic write_len(input logic [REG_IDX_W-1:0] idx, input logic [DUR_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        if (idx < NUM_LEN_REGS)
            len_reg[idx] = val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_all(input logic [DUR_W-1:0] val);
        for (int i = 0; i < NUM_LEN_REGS; i++)
            write_len(i[REG_IDX_W-1:0], val);
    endtask

    task automatic wait_drained(input int pause);
        do begin
            @(posedge aclk);
            #1;
        end while (byte_q.size() != 0 || s_tvalid || seg_q.size() != 0);
        repeat (pause) @(posedge aclk);
        #1;
    endtask

    task automatic push_byte(input logic [7:0] d, input logic f, input logic l);
        byte_q.push_back('{d, f, l});
    endtask

    function automatic logic [7:0] rand_data();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hFF;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // mostly framed messages, some bytes with random framing bits
    task automatic queue_traffic(input int count);
        int added;
        int len;
        added = 0;
        while (added < count) begin
            if ($urandom_range(0, 99) < 85) begin
                len = $urandom_range(1, 6);
                if (len > count - added)
                    len = count - added;
                for (int i = 0; i < len; i++)
                    push_byte(rand_data(), i == 0, i == len - 1);
                added += len;
            end else begin
                push_byte(rand_data(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                added++;
            end
        end
    endtask

    task automatic random_config();
        int r;
        logic [DUR_W-1:0] val;
        for (int i = 0; i < NUM_LEN_REGS; i++) begin
            r = $urandom_range(0, 9);
            if (r == 0)
                val = '0;
            else if (r == 1)
                val = DUR_MAX;
            else
                val = DUR_W'($urandom_range(0, 1023));
            write_len(i[REG_IDX_W-1:0], val);
        end
        if ($urandom_range(0, 1))
            write_len(REG_IDX_NONE, DUR_W'($urandom_range(0, 1023)));
    endtask

    initial begin
        len_reg[REG_HDR_MARK]   = HDR_MARK_RST;
        len_reg[REG_HDR_SPACE]  = HDR_SPACE_RST;
        len_reg[REG_BIT_MARK]   = BIT_MARK_RST;
        len_reg[REG_ONE_SPACE]  = ONE_SPACE_RST;
        len_reg[REG_ZERO_SPACE] = ZERO_SPACE_RST;
        len_reg[REG_FTR_MARK]   = FTR_MARK_RST;
        len_reg[REG_FTR_SPACE]  = FTR_SPACE_RST;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        wait_drained(2);

        push_byte(8'h00, 1'b1, 1'b1);
        push_byte(8'hFF, 1'b1, 1'b1);
        push_byte(8'hA5, 1'b1, 1'b0);
        push_byte(8'h01, 1'b0, 1'b0);
        push_byte(8'h80, 1'b0, 1'b1);
        push_byte(8'h55, 1'b0, 1'b0);
        push_byte(8'hAA, 1'b1, 1'b0);
        push_byte(8'h3C, 1'b1, 1'b0);
        push_byte(8'hC3, 1'b0, 1'b1);
        push_byte(8'h7E, 1'b0, 1'b1);
        push_byte(8'h0F, 1'b1, 1'b1);
        wait_drained(4);

        write_all('0);
        wait_drained(1);
        push_byte(8'h5A, 1'b1, 1'b1);
        push_byte(8'hF0, 1'b1, 1'b0);
        push_byte(8'h0F, 1'b0, 1'b1);
        wait_drained(4);

        write_all(DUR_MAX);
        wait_drained(1);
        push_byte(8'hFF, 1'b1, 1'b1);
        push_byte(8'h00, 1'b1, 1'b0);
        push_byte(8'h96, 1'b0, 1'b1);
        wait_drained(4);

        write_len(REG_ONE_SPACE, 10'd1);
        write_len(REG_IDX_NONE, 10'd0);
        wait_drained(1);
        push_byte(8'h69, 1'b1, 1'b1);
        push_byte(8'h18, 1'b0, 1'b0);
        wait_drained(4);

        for (int p = 0; p < NUM_PHASES; p++) begin
            random_config();
            wait_drained(1);
            quiet = (p == 1);
            queue_traffic(PHASE_ITEMS);
            if (p == 3)
                squeeze = 1'b1;
            wait_drained(4);
        end

        wait_drained(40);
        if (mismatch_count == 0 && seg_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
